// ===== rtl/core/glyph_coverage_blit_rgb565_assert.svh =====
// Assertion macros shared by the blitter modules.
`ifndef GLYPH_COVERAGE_BLIT_RGB565_ASSERT_SVH
`define GLYPH_COVERAGE_BLIT_RGB565_ASSERT_SVH

// Checked at every rising edge of clk_i while rst_ni is high.
`define GCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  `GCB_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/gcb_pkg.sv =====
package gcb_pkg;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_COVER  = 1'b1;

  localparam logic [0:0] CFG_CANVAS_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_CANVAS_HEIGHT = 1'b1;

  localparam logic [31:0] SPREAD_MASK = 32'h07E0_F81F;

  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  py;
    logic [7:0]  px;
  } pixel_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [4:0]  alpha;
    logic [15:0] color;
  } blit_req_t;

  typedef struct packed {
    logic   valid;
    pixel_t pix;
  } blit_res_t;

  // Spreads RGB565 so that green sits in the upper half with headroom per channel.
  function automatic logic [31:0] spread(input logic [15:0] v);
    return {v, v} & SPREAD_MASK;
  endfunction

endpackage

// ===== rtl/core/gcb_fb_ram.sv =====
`include "glyph_coverage_blit_rgb565_assert.svh"

module gcb_fb_ram import gcb_pkg::*; #(
  parameter int unsigned Depth = 65536,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  blit_req_t     req_i,
  input  logic [AW-1:0] addr_i,
  output logic          busy_o,
  output blit_res_t     res_o
);

  logic [15:0]   mem [Depth];
  logic [15:0]   rd_q;
  blit_req_t     s2_q;
  logic [AW-1:0] addr2_q;
  logic          busy_q;
  logic [AW-1:0] clr_q;
  logic          fwd_vld_q;
  logic [AW-1:0] fwd_addr_q;
  logic [15:0]   fwd_data_q;

  logic [15:0]   old_pix;
  logic [31:0]   eo;
  logic [31:0]   ec;
  logic [31:0]   prod;
  logic [31:0]   blend_d;
  logic [15:0]   new_pix;
  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[addr_i];
  end

  always_comb begin
    old_pix = (fwd_vld_q && (fwd_addr_q == addr2_q)) ? fwd_data_q : rd_q;
    eo      = spread(old_pix);
    ec      = spread(s2_q.color);
    prod    = (eo - ec) * {27'd0, s2_q.alpha};
    blend_d = ((prod >> 5) + ec) & SPREAD_MASK;
    new_pix = blend_d[31:16] | blend_d[15:0];
    we      = busy_q || s2_q.valid;
    wa      = busy_q ? clr_q : addr2_q;
    wd      = busy_q ? 16'd0 : new_pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q      <= '0;
      addr2_q   <= '0;
      busy_q    <= 1'b1;
      clr_q     <= '0;
      fwd_vld_q <= 1'b0;
      fwd_addr_q <= '0;
      fwd_data_q <= '0;
    end else begin
      s2_q      <= req_i;
      addr2_q   <= addr_i;
      fwd_vld_q <= s2_q.valid;
      fwd_addr_q <= addr2_q;
      fwd_data_q <= new_pix;
      if (busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == AW'(Depth - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign res_o  = '{valid: s2_q.valid,
                    pix: '{value: new_pix, py: s2_q.py, px: s2_q.px}};

  `GCB_ASSERT(a_no_result_while_clearing, s2_q.valid |-> !busy_q,
              "result produced during framebuffer clear")
  `GCB_ASSERT_NEXT(a_clear_done_stays, !busy_q, !busy_q,
                   "framebuffer clear restarted without reset")
  `GCB_ASSERT(a_stage_follows_request, s2_q.valid |-> $past(req_i.valid),
              "read-modify-write stage valid without a request")

endmodule

// ===== rtl/core/glyph_coverage_blit_rgb565.sv =====
// Channel   Ports                        Carries
// in        s_axis_tvalid/tready/tdata   glyph header or coverage byte (kind on tuser)
// out       m_axis_tvalid/tready/tdata   written pixel: x, y, blended RGB565
// config    cfg_we_i/cfg_idx_i/cfg_data_i canvas width and height
// Sustains one input item per cycle unless stalled; one framebuffer read and one write
// per cycle set it. A pixel passes s1_q, s2_q and the output queue before it is sent.
// After reset the framebuffer is cleared, all MAX_WIDTH*MAX_HEIGHT words (65536 at
// the defaults), with s_axis_tready low; configuration writes are taken meanwhile.
// A four-entry output queue absorbs stalls; the input stalls once it may fill.
`include "glyph_coverage_blit_rgb565_assert.svh"

module glyph_coverage_blit_rgb565 import gcb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pen_x[10:0], pen_y[21:11], left_bearing[30:22], top_bearing[39:31],
  // bitmap_width[47:40], color[63:48], coverage[71:64]
  input  logic [71:0] s_axis_tdata,
  // kind[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x[7:0], pixel_y[15:8], pixel_value[31:16]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int unsigned Depth      = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW         = $clog2(Depth);
  localparam int unsigned XW         = $clog2(MAX_WIDTH);
  localparam int unsigned YW         = $clog2(MAX_HEIGHT);
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PW         = $clog2(FIFO_DEPTH);

  logic signed [10:0] pen_x;
  logic signed [10:0] pen_y;
  logic signed [8:0]  left_bearing;
  logic signed [8:0]  top_bearing;
  logic [7:0]         bitmap_width;
  logic [15:0]        color;
  logic [7:0]         coverage;

  logic [8:0]  canvas_width_q;
  logic [8:0]  canvas_height_q;
  logic [11:0] org_x_q;
  logic [11:0] org_y_q;
  logic [7:0]  row_len_q;
  logic [15:0] color_q;
  logic [7:0]  col_q;
  logic [7:0]  row_q;

  blit_req_t   s1_q;
  logic [XW-1:0] x1_q;
  logic [YW-1:0] y1_q;

  logic        in_acc;
  logic        is_hdr;
  logic [13:0] cur_x;
  logic [13:0] cur_y;
  logic [13:0] lim_w;
  logic [13:0] lim_h;
  logic        in_canvas;
  logic [8:0]  alpha_full;
  logic [7:0]  col_inc;
  logic [AW-1:0] addr;

  logic        busy;
  blit_res_t   res;

  pixel_t      fifo_q [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [2:0]  cnt_q;
  logic [2:0]  occ;
  logic        pop;

  assign pen_x        = s_axis_tdata[10:0];
  assign pen_y        = s_axis_tdata[21:11];
  assign left_bearing = s_axis_tdata[30:22];
  assign top_bearing  = s_axis_tdata[39:31];
  assign bitmap_width = s_axis_tdata[47:40];
  assign color        = s_axis_tdata[63:48];
  assign coverage     = s_axis_tdata[71:64];

  assign occ           = cnt_q + {2'd0, s1_q.valid} + {2'd0, res.valid};
  assign s_axis_tready = !busy && (occ < 3'(FIFO_DEPTH));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_hdr        = s_axis_tuser[0] == KIND_HEADER;

  always_comb begin
    cur_x      = {{2{org_x_q[11]}}, org_x_q} + {6'd0, col_q};
    cur_y      = {{2{org_y_q[11]}}, org_y_q} + {6'd0, row_q};
    lim_w      = ({5'd0, canvas_width_q} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH)
                                                          : {5'd0, canvas_width_q};
    lim_h      = ({5'd0, canvas_height_q} > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT)
                                                            : {5'd0, canvas_height_q};
    in_canvas  = !cur_x[13] && !cur_y[13] && (cur_x < lim_w) && (cur_y < lim_h);
    alpha_full = 9'd256 - {1'b0, coverage};
    col_inc    = col_q + 8'd1;
    addr       = AW'(32'(y1_q) * 32'(MAX_WIDTH) + 32'(x1_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_width_q  <= 9'd256;
      canvas_height_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data_i;
        CFG_CANVAS_HEIGHT: canvas_height_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q   <= '0;
      org_y_q   <= '0;
      row_len_q <= 8'd1;
      color_q   <= '0;
      col_q     <= '0;
      row_q     <= '0;
      s1_q      <= '0;
      x1_q      <= '0;
      y1_q      <= '0;
    end else begin
      s1_q.valid <= in_acc && !is_hdr && (coverage != 8'd0) && in_canvas;
      s1_q.px    <= cur_x[7:0];
      s1_q.py    <= cur_y[7:0];
      s1_q.alpha <= alpha_full[7:3];
      s1_q.color <= color_q;
      x1_q       <= cur_x[XW-1:0];
      y1_q       <= cur_y[YW-1:0];
      if (in_acc) begin
        if (is_hdr) begin
          org_x_q   <= 12'(pen_x) + 12'(left_bearing);
          org_y_q   <= 12'(pen_y) - 12'(top_bearing);
          row_len_q <= (bitmap_width == 8'd0) ? 8'd1 : bitmap_width;
          color_q   <= color;
          col_q     <= '0;
          row_q     <= '0;
        end else if (col_inc >= row_len_q) begin
          col_q <= '0;
          row_q <= row_q + 8'd1;
        end else begin
          col_q <= col_inc;
        end
      end
    end
  end

  gcb_fb_ram #(
    .Depth (Depth)
  ) u_fb_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (s1_q),
    .addr_i (addr),
    .busy_o (busy),
    .res_o  (res)
  );

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = cnt_q != 3'd0;
  assign m_axis_tdata  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      fifo_q[wr_ptr_q] <= res.pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (res.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + {2'd0, res.valid} - {2'd0, pop};
    end
  end

  `GCB_ASSERT(a_queue_bound, occ <= 3'(FIFO_DEPTH),
              "pixels in flight exceed output queue space")
  `GCB_ASSERT(a_column_in_row, col_q < row_len_q,
              "column counter beyond bitmap row length")
  `GCB_ASSERT(a_write_from_coverage,
              s1_q.valid |-> $past(in_acc && (s_axis_tuser[0] == KIND_COVER)),
              "pixel request without an accepted coverage byte")

endmodule

// ===== test/tb_glyph_coverage_blit_rgb565.sv =====
`timescale 1ns / 100ps

module tb_glyph_coverage_blit_rgb565;
  import gcb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int FB_SIDE     = 256;
  localparam int SHOW_LIMIT  = 10;

  typedef enum int {PACE_OUT_SLOW, PACE_IN_SLOW, PACE_FULL} pace_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cov;
    logic [15:0] color;
    logic [7:0]  bw;
    logic [8:0]  tb;
    logic [8:0]  lb;
    logic [10:0] pen_y;
    logic [10:0] pen_x;
  } glyph_req_t;

  typedef struct {
    glyph_req_t req;
    bit         typed;
    bit         hit;
    pixel_t     pix;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [0:0]  cfg_idx_i     = '0;
  logic [8:0]  cfg_data_i    = '0;

  glyph_coverage_blit_rgb565 u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  // Shadow of the blitter state.
  logic [15:0] fb_shadow [0:FB_SIDE*FB_SIDE-1];
  logic [8:0]  canvas_w;
  logic [8:0]  canvas_h;
  int          org_x;
  int          org_y;
  logic [7:0]  row_len;
  logic [15:0] ink;
  logic [7:0]  col_cnt;
  logic [7:0]  row_cnt;

  pixel_t pixq [$];
  dir_row_t dir_tab [$];

  int snd_idle;
  int rcv_idle;
  int cycles;
  int bad_pixels;
  int pixels_seen;
  int req_count;
  int hdr_count;
  int cfg_count;

  initial forever #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels outstanding", cycles, pixq.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      pixels_seen++;
      if (pixq.size() == 0) begin
        bad_pixels++;
        if (bad_pixels <= SHOW_LIMIT)
          $display("Unexpected pixel x=%0d y=%0d value=%04h", got.px, got.py, got.value);
      end else begin
        want = pixq.pop_front();
        if (got.px !== want.px || got.py !== want.py || got.value !== want.value) begin
          bad_pixels++;
          if (bad_pixels <= SHOW_LIMIT)
            $display("Pixel mismatch: expected x=%0d y=%0d value=%04h, got x=%0d y=%0d value=%04h",
                     want.px, want.py, want.value, got.px, got.py, got.value);
        end
      end
    end
  end

  function automatic logic [15:0] mix_rgb565(logic [15:0] old, logic [15:0] fg, logic [7:0] cov);
    logic [31:0] alpha;
    logic [31:0] eo;
    logic [31:0] ec;
    logic [31:0] d;
    alpha = (32'd256 - 32'(cov)) >> 3;
    eo = {old, old} & SPREAD_MASK;
    ec = {fg, fg} & SPREAD_MASK;
    d = ((((eo - ec) * alpha) >> 5) + ec) & SPREAD_MASK;
    return d[31:16] | d[15:0];
  endfunction

  function automatic void blit_predict(glyph_req_t r, output bit hit, output pixel_t pix);
    int x;
    int y;
    int lim_w;
    int lim_h;
    int idx;
    hit = 1'b0;
    pix = '0;
    if (r.kind == KIND_HEADER) begin
      org_x = $signed(r.pen_x) + $signed(r.lb);
      org_y = $signed(r.pen_y) - $signed(r.tb);
      row_len = (r.bw == 8'd0) ? 8'd1 : r.bw;
      ink = r.color;
      col_cnt = '0;
      row_cnt = '0;
      return;
    end
    x = org_x + int'(col_cnt);
    y = org_y + int'(row_cnt);
    col_cnt = col_cnt + 8'd1;
    if (col_cnt >= row_len) begin
      col_cnt = '0;
      row_cnt = row_cnt + 8'd1;
    end
    if (r.cov == 8'd0) return;
    lim_w = (canvas_w > FB_SIDE) ? FB_SIDE : int'(canvas_w);
    lim_h = (canvas_h > FB_SIDE) ? FB_SIDE : int'(canvas_h);
    if (x < 0 || y < 0 || x >= lim_w || y >= lim_h) return;
    idx = y * FB_SIDE + x;
    fb_shadow[idx] = mix_rgb565(fb_shadow[idx], ink, r.cov);
    hit = 1'b1;
    pix.px = 8'(x);
    pix.py = 8'(y);
    pix.value = fb_shadow[idx];
  endfunction

  function automatic glyph_req_t any_req();
    glyph_req_t r;
    r.kind  = 1'($urandom);
    r.cov   = 8'($urandom);
    r.color = 16'($urandom);
    r.bw    = 8'($urandom);
    r.tb    = 9'($urandom);
    r.lb    = 9'($urandom);
    r.pen_y = 11'($urandom);
    r.pen_x = 11'($urandom);
    return r;
  endfunction

  function automatic logic [7:0] pick_cov();
    case ($urandom_range(0, 19))
      0, 1, 2: return 8'd0;
      3, 4, 5: return 8'd255;
      6, 7:    return 8'($urandom_range(1, 7));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic dir_row_t hdr_row(int px, int py, int lb, int tb, int bw, int col);
    dir_row_t row;
    row.req = '0;
    row.req.kind = KIND_HEADER;
    row.req.pen_x = 11'(px);
    row.req.pen_y = 11'(py);
    row.req.lb = 9'(lb);
    row.req.tb = 9'(tb);
    row.req.bw = 8'(bw);
    row.req.color = 16'(col);
    row.typed = 1'b1;
    row.hit = 1'b0;
    row.pix = '0;
    return row;
  endfunction

  function automatic dir_row_t cov_row(int cov, bit typed, bit hit, int x, int y, int v);
    dir_row_t row;
    row.req = '0;
    row.req.kind = KIND_COVER;
    row.req.cov = 8'(cov);
    row.typed = typed;
    row.hit = hit;
    row.pix.px = 8'(x);
    row.pix.py = 8'(y);
    row.pix.value = 16'(v);
    return row;
  endfunction

  function automatic void set_pace(pace_e pace);
    case (pace)
      PACE_OUT_SLOW: begin
        snd_idle = 14;
        rcv_idle = 59;
      end
      PACE_IN_SLOW: begin
        snd_idle = 59;
        rcv_idle = 14;
      end
      default: begin
        snd_idle = 0;
        rcv_idle = 0;
      end
    endcase
  endfunction

  task automatic send_req(glyph_req_t r, bit typed, bit t_hit, pixel_t t_pix);
    bit hit;
    pixel_t pix;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r.cov, r.color, r.bw, r.tb, r.lb, r.pen_y, r.pen_x};
    s_axis_tuser <= r.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    blit_predict(r, hit, pix);
    if (typed) begin
      hit = t_hit;
      pix = t_pix;
    end
    if (hit) pixq.push_back(pix);
    req_count++;
    if (r.kind == KIND_HEADER) hdr_count++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pixq.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [0:0] idx, int v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 9'(v);
    if (idx == CFG_CANVAS_WIDTH) canvas_w = 9'(v);
    else canvas_h = 9'(v);
    cfg_count++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_glyphs(int n);
    int sent;
    int lim_w;
    int lim_h;
    int len;
    glyph_req_t r;
    sent = 0;
    lim_w = (canvas_w > FB_SIDE) ? FB_SIDE : int'(canvas_w);
    lim_h = (canvas_h > FB_SIDE) ? FB_SIDE : int'(canvas_h);
    while (sent < n) begin
      if ($urandom_range(0, 99) < 8) begin
        send_req(any_req(), 1'b0, 1'b0, '0);
        sent++;
      end else begin
        r = any_req();
        r.kind = KIND_HEADER;
        r.pen_x = 11'(int'($urandom_range(0, lim_w + 23)) - 16);
        r.lb = 9'(int'($urandom_range(0, 16)) - 8);
        r.pen_y = 11'(int'($urandom_range(0, lim_h + 23)) - 8);
        r.tb = 9'(int'($urandom_range(0, 16)) - 4);
        case ($urandom_range(0, 19))
          0:          r.bw = 8'd0;
          1:          r.bw = 8'd255;
          2, 3, 4, 5: r.bw = 8'($urandom_range(13, 40));
          default:    r.bw = 8'($urandom_range(1, 12));
        endcase
        len = ((r.bw == 8'd0) ? 1 : int'(r.bw)) * int'($urandom_range(1, 10));
        if (len > 48) len = $urandom_range(1, 48);
        if ($urandom_range(0, 9) == 0) len = $urandom_range(0, len);
        send_req(r, 1'b0, 1'b0, '0);
        sent++;
        repeat (len) begin
          r = any_req();
          r.kind = KIND_COVER;
          r.cov = pick_cov();
          send_req(r, 1'b0, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  int ph_w [7] = '{256, 511, 1, 0, 100, 200, 37};
  int ph_h [7] = '{256, 511, 1, 0, 60, 256, 256};
  int ph_n [7] = '{300, 150, 60, 40, 250, 200, 200};
  pace_e ph_pace [7] = '{PACE_OUT_SLOW, PACE_OUT_SLOW, PACE_IN_SLOW, PACE_IN_SLOW,
                         PACE_IN_SLOW, PACE_FULL, PACE_FULL};

  initial begin
    glyph_req_t r;
    for (int i = 0; i < FB_SIDE * FB_SIDE; i++) fb_shadow[i] = '0;
    canvas_w = 9'd256;
    canvas_h = 9'd256;
    org_x = 0;
    org_y = 0;
    row_len = 8'd1;
    ink = '0;
    col_cnt = '0;
    row_cnt = '0;
    bad_pixels = 0;
    pixels_seen = 0;
    req_count = 0;
    hdr_count = 0;
    cfg_count = 0;
    set_pace(PACE_OUT_SLOW);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cfg_write(CFG_CANVAS_WIDTH, 256);
    cfg_write(CFG_CANVAS_HEIGHT, 256);

    dir_tab.push_back(cov_row(255, 1, 1, 0, 0, 'h0000));
    dir_tab.push_back(cov_row(8, 1, 1, 0, 1, 'h0000));
    dir_tab.push_back(hdr_row(10, 20, 0, 0, 4, 'hFFFF));
    dir_tab.push_back(cov_row(255, 1, 1, 10, 20, 'hFFFF));
    dir_tab.push_back(cov_row(0, 1, 0, 0, 0, 0));
    dir_tab.push_back(cov_row(1, 0, 0, 0, 0, 0));
    dir_tab.push_back(cov_row(128, 0, 0, 0, 0, 0));
    dir_tab.push_back(cov_row(255, 1, 1, 10, 21, 'hFFFF));
    dir_tab.push_back(hdr_row(10, 20, 0, 0, 1, 'h0000));
    dir_tab.push_back(cov_row(128, 0, 0, 0, 0, 0));
    dir_tab.push_back(cov_row(7, 0, 0, 0, 0, 0));
    dir_tab.push_back(hdr_row(-1024, -1024, -256, 255, 255, 'h0000));
    dir_tab.push_back(cov_row(255, 1, 0, 0, 0, 0));
    dir_tab.push_back(hdr_row(1023, 1023, 255, -256, 1, 'hA5A5));
    dir_tab.push_back(cov_row(200, 1, 0, 0, 0, 0));
    dir_tab.push_back(hdr_row(255, 255, 0, 0, 0, 'h5A5A));
    dir_tab.push_back(cov_row(255, 1, 1, 255, 255, 'h5A5A));
    dir_tab.push_back(cov_row(255, 1, 0, 0, 0, 0));
    dir_tab.push_back(hdr_row(-2, 5, 0, 0, 4, 'h1234));
    dir_tab.push_back(cov_row(255, 1, 0, 0, 0, 0));
    dir_tab.push_back(cov_row(255, 1, 0, 0, 0, 0));
    dir_tab.push_back(cov_row(255, 1, 1, 0, 5, 'h1234));
    dir_tab.push_back(cov_row(255, 1, 1, 1, 5, 'h1234));
    dir_tab.push_back(hdr_row(100, 50, -20, 10, 2, 'h8001));
    dir_tab.push_back(cov_row(255, 1, 1, 80, 40, 'h8001));

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].hit,
                                  dir_tab[i].pix);

    for (int p = 0; p < 7; p++) begin
      settle();
      cfg_write(CFG_CANVAS_WIDTH, ph_w[p]);
      cfg_write(CFG_CANVAS_HEIGHT, ph_h[p]);
      set_pace(ph_pace[p]);
      if (p == 0) begin
        // A one-pixel-wide glyph taller than 256 rows wraps back to its top row.
        r = any_req();
        r.kind = KIND_HEADER;
        r.pen_x = 11'd37;
        r.pen_y = 11'd0;
        r.lb = '0;
        r.tb = '0;
        r.bw = 8'd1;
        send_req(r, 1'b0, 1'b0, '0);
        repeat (258) begin
          r = any_req();
          r.kind = KIND_COVER;
          r.cov = 8'($urandom_range(1, 255));
          send_req(r, 1'b0, 1'b0, '0);
        end
        run_glyphs(ph_n[p] / 2);
        settle();
        run_glyphs(ph_n[p] / 2);
      end else begin
        run_glyphs(ph_n[p]);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (pixq.size() != 0) begin
      bad_pixels += pixq.size();
      $display("%0d expected pixels never appeared", pixq.size());
    end
    $display("Sent %0d requests (%0d glyph headers) over %0d canvas register writes,",
             req_count, hdr_count, cfg_count);
    $display("checked %0d written pixels, %0d of them wrong or unexpected.",
             pixels_seen, bad_pixels);
    if (bad_pixels == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
